>>> design/aeod_pkg.sv
// ----------------------------------------------------------------------------
// aeod_pkg: shared types and constants for the archive entry overlap detector
// Table depth, field widths, range type and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package aeod_pkg;

    localparam int unsigned MAX_ENTRIES  = 32;
    localparam int unsigned ADDR_W       = $clog2(MAX_ENTRIES);
    localparam int unsigned CNT_W        = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned POS_W        = 32;
    localparam int unsigned LEN_W        = 16;
    localparam logic [POS_W-1:0] HEADER_FIXED = POS_W'(30);

    localparam logic KIND_REPORT  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] stop;
    } range_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        range_t            data;
    } tbl_wr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_FIN,
        ST_SCAN,
        ST_SUMMARY
    } seq_state_t;

endpackage

`default_nettype wire

>>> design/aeod_range_table.sv
// ----------------------------------------------------------------------------
// aeod_range_table: stored byte ranges of the current archive
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module aeod_range_table
    import aeod_pkg::*;
(
    input  wire logic              aclk,
    input  wire tbl_wr_t           wr,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output range_t                 rd_data
);

    range_t mem [MAX_ENTRIES];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> design/archive_entry_overlap_detector.sv
// ----------------------------------------------------------------------------
// archive_entry_overlap_detector: overlap check of archive entry byte ranges
//
// Input channel (s_*): one entry descriptor per word. The block forms the range
// [offset, offset + 30 + name + extra + packed) modulo 2^32 and checks it
// against every range stored so far for the current archive.
// Result channel (m_*): one report word per overlapping stored entry, in
// stored order, then one summary word with the overlap count (m_last_item set).
// The range is then stored unless the table of 32 entries is full.
// s_first_entry empties the table before the entry is checked.
//
// Timing: in an accept cycle the item is taken in, ST_SUM adds the header,
// name and extra lengths to the packed size, and ST_FIN forms the end
// address. In ST_SCAN the shared compare unit walks the table one entry per
// cycle behind the registered table read, unless a stalled receiver holds
// it, and drains the last compare; ST_SUMMARY then issues the summary.
// s_ready is high only while no item is in work.
// A stalled receiver holds the scan when a report or summary must be issued.
// Reset empties the table and clears the output register; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module archive_entry_overlap_detector
    import aeod_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,

    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic             s_first_entry,
    input  wire logic [POS_W-1:0] s_entry_offset,
    input  wire logic [LEN_W-1:0] s_name_length,
    input  wire logic [LEN_W-1:0] s_extra_length,
    input  wire logic [POS_W-1:0] s_packed_size,

    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic                  m_item_kind,
    output logic [4:0]            m_other_index,
    output logic [5:0]            m_entry_index,
    output logic [5:0]            m_overlap_count,
    output logic                  m_table_full,
    output logic                  m_last_item
);

    seq_state_t state_reg, state_next;

    logic [CNT_W-1:0] stored_count_reg, stored_count_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic [CNT_W-1:0] ovl_cnt_reg, ovl_cnt_next;

    logic [POS_W-1:0] start_reg, start_next;
    logic [POS_W-1:0] stop_reg, stop_next;
    logic [POS_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] name_reg, name_next;
    logic [LEN_W-1:0] extra_reg, extra_next;

    logic             m_valid_reg, m_valid_next;
    logic             kind_reg, kind_next;
    logic [4:0]       other_reg, other_next;
    logic [5:0]       eidx_reg, eidx_next;
    logic [5:0]       ocnt_reg, ocnt_next;
    logic             full_reg, full_next;
    logic             last_reg, last_next;

    tbl_wr_t           tbl_wr;
    logic [ADDR_W-1:0] rd_addr;
    range_t            rd_data;

    logic             out_busy;
    logic             hit;
    logic             stall;
    logic             tbl_full;
    logic [5:0]       entry_idx;

    aeod_range_table u_table (
        .aclk    (aclk),
        .wr      (tbl_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_busy  = m_valid_reg && !m_ready;
    assign hit       = cmp_vld_reg && (start_reg < rd_data.stop) && (stop_reg > rd_data.start);
    assign stall     = hit && out_busy;
    assign rd_addr   = stall ? cmp_idx_reg[ADDR_W-1:0] : scan_idx_reg[ADDR_W-1:0];
    assign tbl_full  = (count_reg >= CNT_W'(MAX_ENTRIES));
    assign entry_idx = tbl_full ? 6'(MAX_ENTRIES) : 6'(count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            stored_count_reg <= '0;
            cmp_vld_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            stored_count_reg <= stored_count_next;
            cmp_vld_reg      <= cmp_vld_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        count_reg    <= count_next;
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        ovl_cnt_reg  <= ovl_cnt_next;
        start_reg    <= start_next;
        stop_reg     <= stop_next;
        len_reg      <= len_next;
        name_reg     <= name_next;
        extra_reg    <= extra_next;
        kind_reg     <= kind_next;
        other_reg    <= other_next;
        eidx_reg     <= eidx_next;
        ocnt_reg     <= ocnt_next;
        full_reg     <= full_next;
        last_reg     <= last_next;
    end

    always_comb begin
        state_next        = state_reg;
        stored_count_next = stored_count_reg;
        count_next        = count_reg;
        scan_idx_next     = scan_idx_reg;
        cmp_idx_next      = cmp_idx_reg;
        cmp_vld_next      = cmp_vld_reg;
        ovl_cnt_next      = ovl_cnt_reg;
        start_next        = start_reg;
        stop_next         = stop_reg;
        len_next          = len_reg;
        name_next         = name_reg;
        extra_next        = extra_reg;
        m_valid_next      = out_busy;
        kind_next         = kind_reg;
        other_next        = other_reg;
        eidx_next         = eidx_reg;
        ocnt_next         = ocnt_reg;
        full_next         = full_reg;
        last_next         = last_reg;
        tbl_wr.en         = 1'b0;
        tbl_wr.addr       = count_reg[ADDR_W-1:0];
        tbl_wr.data.start = start_reg;
        tbl_wr.data.stop  = stop_reg;
        s_ready           = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    start_next   = s_entry_offset;
                    len_next     = s_packed_size;
                    name_next    = s_name_length;
                    extra_next   = s_extra_length;
                    count_next   = s_first_entry ? '0 : stored_count_reg;
                    state_next   = ST_SUM;
                end
            end
            ST_SUM: begin
                len_next   = len_reg + HEADER_FIXED + POS_W'(name_reg) + POS_W'(extra_reg);
                state_next = ST_FIN;
            end
            ST_FIN: begin
                stop_next     = start_reg + len_reg;
                scan_idx_next = '0;
                ovl_cnt_next  = '0;
                cmp_vld_next  = 1'b0;
                state_next    = ST_SCAN;
            end
            ST_SCAN: begin
                if (!stall) begin
                    if (hit) begin
                        m_valid_next = 1'b1;
                        kind_next    = KIND_REPORT;
                        other_next   = cmp_idx_reg[4:0];
                        eidx_next    = entry_idx;
                        ocnt_next    = '0;
                        full_next    = 1'b0;
                        last_next    = 1'b0;
                        ovl_cnt_next = ovl_cnt_reg + 1'b1;
                    end
                    if (scan_idx_reg < count_reg) begin
                        cmp_vld_next  = 1'b1;
                        cmp_idx_next  = scan_idx_reg;
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end else begin
                        cmp_vld_next = 1'b0;
                        if (!cmp_vld_reg) begin
                            state_next = ST_SUMMARY;
                        end
                    end
                end
            end
            ST_SUMMARY: begin
                if (!out_busy) begin
                    m_valid_next = 1'b1;
                    kind_next    = KIND_SUMMARY;
                    other_next   = '0;
                    eidx_next    = entry_idx;
                    ocnt_next    = 6'(ovl_cnt_reg);
                    full_next    = tbl_full;
                    last_next    = 1'b1;
                    if (!tbl_full) begin
                        tbl_wr.en         = 1'b1;
                        stored_count_next = count_reg + 1'b1;
                    end else begin
                        stored_count_next = count_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid         = m_valid_reg;
    assign m_item_kind     = kind_reg;
    assign m_other_index   = other_reg;
    assign m_entry_index   = eidx_reg;
    assign m_overlap_count = ocnt_reg;
    assign m_table_full    = full_reg;
    assign m_last_item     = last_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stored_count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("stored count exceeds table depth");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_SUM))
        else $error("accepted word did not start the sequencer");

    a_idle_no_cmp: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !cmp_vld_reg)
        else $error("compare stage active while idle");

    a_last_is_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (last_reg == kind_reg))
        else $error("last flag and summary kind disagree");

    a_write_only_room: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_wr.en |-> (count_reg < CNT_W'(MAX_ENTRIES)))
        else $error("table written while full");

endmodule

`default_nettype wire
